FILE: rtl/core/cfp_pkg.sv
package cfp_pkg;

  localparam int unsigned PacketBytesADef = 896;
  localparam int unsigned PacketBytesBDef = 960;

  localparam int unsigned FillW  = 10;
  localparam int unsigned HdrIdxW = 4;

  localparam int unsigned FifoDepth = 2;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  localparam logic CfgVariant = 1'b0;
  localparam logic CfgJpeg    = 1'b1;

  localparam logic [4:0] HdrBytesA = 5'd16;
  localparam logic [4:0] HdrBytesB = 5'd9;

  typedef struct packed {
    logic [7:0] data;
    logic       hdr;
    logic       ftr;
    logic       pe;
    logic       pad;
    logic       variant;
    logic       jpeg;
  } cmd_t;

  function automatic logic [HdrIdxW-1:0] blk_last_idx(input logic variant,
                                                     input logic footer);
    logic [HdrIdxW-1:0] r;
    if (!variant) begin
      r = 4'd15;
    end else if (footer) begin
      r = 4'd10;
    end else begin
      r = 4'd8;
    end
    return r;
  endfunction

  function automatic logic [7:0] blk_byte(input logic variant, input logic jpeg,
                                          input logic footer,
                                          input logic [HdrIdxW-1:0] idx);
    logic [7:0] r;
    r = 8'h00;
    if (!variant) begin
      case (idx)
        4'd0, 4'd1, 4'd2: r = 8'hFF;
        4'd3:             r = footer ? 8'h51 : 8'h50;
        4'd10:            r = jpeg ? 8'h03 : 8'h01;
        default:          r = 8'h00;
      endcase
    end else begin
      case (idx)
        4'd8:    r = footer ? 8'hA8 : 8'h28;
        4'd9:    r = footer ? 8'h09 : 8'h00;
        4'd10:   r = footer ? 8'h07 : 8'h00;
        default: r = 8'h00;
      endcase
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/cfp_if.sv
interface cfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_end;

  modport source (output valid, output frame_byte, output frame_end, input ready);
  modport sink   (input valid, input frame_byte, input frame_end, output ready);
endinterface

interface cfp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       packet_end;
  logic       pad_rest;
  logic       run_last;

  modport source (output valid, output out_byte, output packet_end, output pad_rest,
                  output run_last, input ready);
  modport sink   (input valid, input out_byte, input packet_end, input pad_rest,
                  input run_last, output ready);
endinterface

FILE: rtl/core/camera_frame_packetizer_core.sv
// Channel   Role    Payload
// in_i      sink    frame_byte[7:0], frame_end
// out_o     source  out_byte[7:0], packet_end, pad_rest, run_last
// cfg       write   cfg_we_i, cfg_idx_i, cfg_data_i
//
// One result per cycle leaves the output register while out_o.ready holds.
// A frame's first item adds 16 (or 9) header bytes, its last 16 (or 11) footer bytes.
// The front takes an item per cycle while the two-entry command queue has room.
// Reset zeroes config, frame tracking, the queue and out valid, not the output data.
// Out stalls hold the output register and back the queue up into in_i.ready.
module camera_frame_packetizer_core #(
  parameter int unsigned PACKET_BYTES_A = cfp_pkg::PacketBytesADef,
  parameter int unsigned PACKET_BYTES_B = cfp_pkg::PacketBytesBDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cfp_in_if.sink     in_i,
  cfp_out_if.source  out_o,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic       cfg_data_i
);
  import cfp_pkg::*;

  logic variant_q, jpeg_q;
  logic push, pop, q_full, q_empty;
  cmd_t push_cmd, head_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      variant_q <= 1'b0;
      jpeg_q    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgVariant: variant_q <= cfg_data_i;
        CfgJpeg:    jpeg_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  cfp_front #(
    .PACKET_BYTES_A(PACKET_BYTES_A),
    .PACKET_BYTES_B(PACKET_BYTES_B)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .variant_i (variant_q),
    .jpeg_i    (jpeg_q),
    .q_full_i  (q_full),
    .push_o    (push),
    .cmd_o     (push_cmd)
  );

  cfp_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head_cmd),
    .empty_o    (q_empty),
    .full_o     (q_full)
  );

  cfp_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (head_cmd),
    .q_empty_i (q_empty),
    .pop_o     (pop),
    .out_o     (out_o)
  );

endmodule

FILE: rtl/core/cfp_fifo.sv
module cfp_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  cfp_pkg::cmd_t push_cmd_i,
  input  logic          pop_i,
  output cfp_pkg::cmd_t head_o,
  output logic          empty_o,
  output logic          full_o
);
  import cfp_pkg::*;

  cmd_t                mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoCntW-1:0] cnt_q;
  logic                do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == FifoCntW'(FifoDepth));
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

FILE: rtl/core/cfp_front.sv
module cfp_front #(
  parameter int unsigned PACKET_BYTES_A = cfp_pkg::PacketBytesADef,
  parameter int unsigned PACKET_BYTES_B = cfp_pkg::PacketBytesBDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  cfp_in_if.sink        in_i,
  input  logic          variant_i,
  input  logic          jpeg_i,
  input  logic          q_full_i,
  output logic          push_o,
  output cfp_pkg::cmd_t cmd_o
);
  import cfp_pkg::*;

  localparam logic [FillW:0] SizeA = (FillW + 1)'(PACKET_BYTES_A);
  localparam logic [FillW:0] SizeB = (FillW + 1)'(PACKET_BYTES_B);

  logic             in_frame_q, in_frame_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic [FillW-1:0] base;
  logic [FillW:0]   next, size;
  logic             full;

  assign in_i.ready = !q_full_i;
  assign push_o     = in_i.valid && !q_full_i;

  always_comb begin
    base = in_frame_q ? fill_q
                      : (variant_i ? FillW'(HdrBytesB) : FillW'(HdrBytesA));
    next = {1'b0, base} + 1'b1;
    size = variant_i ? SizeB : SizeA;
    full = (next >= size);

    cmd_o.data    = in_i.frame_byte;
    cmd_o.hdr     = !in_frame_q;
    cmd_o.ftr     = in_i.frame_end;
    cmd_o.pe      = in_i.frame_end || full;
    cmd_o.pad     = in_i.frame_end && !full;
    cmd_o.variant = variant_i;
    cmd_o.jpeg    = jpeg_i;

    in_frame_d = in_frame_q;
    fill_d     = fill_q;
    if (push_o) begin
      if (in_i.frame_end) begin
        in_frame_d = 1'b0;
        fill_d     = '0;
      end else begin
        in_frame_d = 1'b1;
        fill_d     = full ? '0 : next[FillW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      fill_q     <= '0;
    end else begin
      in_frame_q <= in_frame_d;
      fill_q     <= fill_d;
    end
  end

endmodule

FILE: rtl/core/cfp_back.sv
module cfp_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cfp_pkg::cmd_t cmd_i,
  input  logic          q_empty_i,
  output logic          pop_o,
  cfp_out_if.source     out_o
);
  import cfp_pkg::*;

  typedef enum logic [1:0] {
    PhHdr,
    PhByte,
    PhFtr
  } phase_e;

  phase_e             phase_q, phase_d, eff;
  logic [HdrIdxW-1:0] idx_q, idx_d;
  logic               advance, fire, idx_last;
  logic               ovalid_q, ovalid_d;
  logic [7:0]         obyte_q, obyte_d;
  logic               ope_q, ope_d, opad_q, opad_d, olast_q, olast_d;

  assign advance = !ovalid_q || out_o.ready;
  assign fire    = advance && !q_empty_i;

  assign out_o.valid      = ovalid_q;
  assign out_o.out_byte   = obyte_q;
  assign out_o.packet_end = ope_q;
  assign out_o.pad_rest   = opad_q;
  assign out_o.run_last   = olast_q;

  always_comb begin
    eff      = (phase_q == PhHdr && !cmd_i.hdr) ? PhByte : phase_q;
    idx_last = (idx_q == blk_last_idx(cmd_i.variant, eff == PhFtr));
    phase_d  = phase_q;
    idx_d    = idx_q;
    pop_o    = 1'b0;
    ovalid_d = advance ? 1'b0 : ovalid_q;
    obyte_d  = obyte_q;
    ope_d    = ope_q;
    opad_d   = opad_q;
    olast_d  = olast_q;
    if (fire) begin
      ovalid_d = 1'b1;
      unique case (eff)
        PhHdr: begin
          obyte_d = blk_byte(cmd_i.variant, cmd_i.jpeg, 1'b0, idx_q);
          ope_d   = 1'b0;
          opad_d  = 1'b0;
          olast_d = 1'b0;
          if (idx_last) begin
            phase_d = PhByte;
            idx_d   = '0;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
        PhByte: begin
          obyte_d = cmd_i.data;
          ope_d   = cmd_i.pe;
          opad_d  = cmd_i.pad;
          olast_d = !cmd_i.ftr;
          idx_d   = '0;
          if (cmd_i.ftr) begin
            phase_d = PhFtr;
          end else begin
            phase_d = PhHdr;
            pop_o   = 1'b1;
          end
        end
        PhFtr: begin
          obyte_d = blk_byte(cmd_i.variant, cmd_i.jpeg, 1'b1, idx_q);
          ope_d   = idx_last;
          opad_d  = idx_last;
          olast_d = idx_last;
          if (idx_last) begin
            phase_d = PhHdr;
            idx_d   = '0;
            pop_o   = 1'b1;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
        default: begin
          phase_d = PhHdr;
          idx_d   = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhHdr;
      idx_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      idx_q    <= idx_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    obyte_q <= obyte_d;
    ope_q   <= ope_d;
    opad_q  <= opad_d;
    olast_q <= olast_d;
  end

endmodule
